### hw/rtl/ps2mt_pkg.sv
// Shared constants and types of the PS/2 mouse packet tracker.
// No dependencies; every other RTL file of the block imports this package.
package ps2mt_pkg;

   // Default width of the pointer coordinates
   localparam int COORD_BITS_DEF = 12;

   // Width of the screen limit registers
   localparam int DIM_BITS = 13;

   localparam logic [DIM_BITS-1:0] SCREEN_WIDTH_RST  = DIM_BITS'(1024);
   localparam logic [DIM_BITS-1:0] SCREEN_HEIGHT_RST = DIM_BITS'(768);

   // Pointer position after reset
   localparam int X_TRACK_RST = 5;
   localparam int Y_TRACK_RST = 2;

   // Register indexes on the CSR port (byte address is 4 * index)
   localparam logic REG_SCREEN_WIDTH  = 1'b0;
   localparam logic REG_SCREEN_HEIGHT = 1'b1;
   localparam int   CSR_ADDR_BITS     = 3;
   localparam int   CSR_DATA_BITS     = 32;

   // Status byte bit positions
   localparam int STAT_LEFT   = 0;
   localparam int STAT_RIGHT  = 1;
   localparam int STAT_MIDDLE = 2;
   localparam int STAT_X_OVF  = 6;
   localparam int STAT_Y_OVF  = 7;

   // Screen limits handed from the CSR block to the datapath
   typedef struct packed {
      logic [DIM_BITS-1:0] screen_width;
      logic [DIM_BITS-1:0] screen_height;
   } cfg_type;

endpackage

### hw/rtl/ps2mt_if.sv
// Valid/ready channel interfaces of the PS/2 mouse packet tracker.
// Depends on ps2mt_pkg for the default coordinate width.
interface ps2mt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface ps2mt_rsp_if import ps2mt_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] x_position;
   logic [COORD_BITS-1:0] y_position;
   logic                  left_pressed;
   logic                  right_pressed;
   logic                  middle_pressed;
   logic                  x_overflowed;
   logic                  y_overflowed;
   logic [7:0]            packet_status;

   modport source (output valid, output x_position, output y_position,
                   output left_pressed, output right_pressed, output middle_pressed,
                   output x_overflowed, output y_overflowed, output packet_status,
                   input ready);
   modport sink   (input valid, input x_position, input y_position,
                   input left_pressed, input right_pressed, input middle_pressed,
                   input x_overflowed, input y_overflowed, input packet_status,
                   output ready);
endinterface

### hw/rtl/ps2mt_csr.sv
// APB-style register block holding the screen width and height limits.
// Depends on ps2mt_pkg for register indexes, widths and reset values.
module ps2mt_csr import ps2mt_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready,
   output cfg_type                  cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;
   logic    reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_sel    = csr_paddr[2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_SCREEN_WIDTH:  cfg_in.screen_width  = csr_pwdata[DIM_BITS-1:0];
            REG_SCREEN_HEIGHT: cfg_in.screen_height = csr_pwdata[DIM_BITS-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_SCREEN_WIDTH:  csr_prdata = CSR_DATA_BITS'(cfg_ff.screen_width);
         REG_SCREEN_HEIGHT: csr_prdata = CSR_DATA_BITS'(cfg_ff.screen_height);
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.screen_width  <= SCREEN_WIDTH_RST;
         cfg_ff.screen_height <= SCREEN_HEIGHT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hw/rtl/ps2mt_core.sv
// Packet assembly, pointer update and clamping, with a registered result beat.
// Depends on ps2mt_pkg and the channel interfaces in ps2mt_if.sv.
module ps2mt_core import ps2mt_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   ps2mt_req_if.sink    req_bus,
   ps2mt_rsp_if.source  rsp_bus
);

   // Wide enough for a signed sum and for any limit value
   localparam int CMP_W = (COORD_BITS + 2 > DIM_BITS + 1) ? COORD_BITS + 2 : DIM_BITS + 1;
   localparam logic [CMP_W-1:0] CAP = CMP_W'(1) << COORD_BITS;

   typedef enum logic [1:0] {
      IDX_STATUS,
      IDX_DX,
      IDX_DY
   } idx_type;

   idx_type               idx_ff, idx_in;
   logic [7:0]            held_status_ff, held_status_in;
   logic [7:0]            held_dx_ff, held_dx_in;
   logic [COORD_BITS-1:0] x_track_ff, x_track_in;
   logic [COORD_BITS-1:0] y_track_ff, y_track_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_status_ff, rsp_status_in;
   logic [COORD_BITS-1:0] rsp_x_ff, rsp_y_ff;

   logic                  accept;
   logic                  out_free;
   logic [CMP_W-1:0]      nx, ny;
   logic [COORD_BITS-1:0] x_clamp, y_clamp;

   function automatic logic [CMP_W-1:0] limit_of(input logic [DIM_BITS-1:0] dim);
      logic [CMP_W-1:0] lim;
      lim = CMP_W'(dim);
      if (lim == '0) begin
         lim = CMP_W'(1);
      end else if (lim > CAP) begin
         lim = CAP;
      end
      return lim;
   endfunction

   function automatic logic [COORD_BITS-1:0] clamp_coord(input logic [CMP_W-1:0] v,
                                                          input logic [DIM_BITS-1:0] dim);
      logic [CMP_W-1:0] lim;
      lim = limit_of(dim);
      if (v[CMP_W-1]) begin
         return '0;
      end else if (v >= lim) begin
         return COORD_BITS'(lim - CMP_W'(1));
      end else begin
         return v[COORD_BITS-1:0];
      end
   endfunction

   // Output register is free when empty or drained this cycle
   assign out_free      = ~rsp_valid_ff | rsp_bus.ready;
   // Status and X-delta beats make no result and never wait on the output
   assign req_bus.ready = out_free | (idx_ff != IDX_DY);
   assign accept        = req_bus.valid & req_bus.ready;

   assign nx = {{(CMP_W-COORD_BITS){1'b0}}, x_track_ff}
             + {{(CMP_W-8){held_dx_ff[7]}}, held_dx_ff};
   assign ny = {{(CMP_W-COORD_BITS){1'b0}}, y_track_ff}
             - {{(CMP_W-8){req_bus.data_byte[7]}}, req_bus.data_byte};
   assign x_clamp = clamp_coord(nx, cfg.screen_width);
   assign y_clamp = clamp_coord(ny, cfg.screen_height);

   always_comb begin
      idx_in         = idx_ff;
      held_status_in = held_status_ff;
      held_dx_in     = held_dx_ff;
      x_track_in     = x_track_ff;
      y_track_in     = y_track_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_bus.ready;
      if (accept) begin
         unique case (idx_ff)
            IDX_DX: begin
               held_dx_in = req_bus.data_byte;
               idx_in     = IDX_DY;
            end
            IDX_DY: begin
               x_track_in    = x_clamp;
               y_track_in    = y_clamp;
               rsp_status_in = held_status_ff;
               rsp_valid_in  = 1'b1;
               idx_in        = IDX_STATUS;
            end
            default: begin
               // unused index code falls back to a status beat
               held_status_in = req_bus.data_byte;
               idx_in         = IDX_DX;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff         <= IDX_STATUS;
         held_status_ff <= '0;
         held_dx_ff     <= '0;
         x_track_ff     <= COORD_BITS'(X_TRACK_RST);
         y_track_ff     <= COORD_BITS'(Y_TRACK_RST);
         rsp_valid_ff   <= 1'b0;
      end else begin
         idx_ff         <= idx_in;
         held_status_ff <= held_status_in;
         held_dx_ff     <= held_dx_in;
         x_track_ff     <= x_track_in;
         y_track_ff     <= y_track_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_x_ff      <= x_track_in;
      rsp_y_ff      <= y_track_in;
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.x_position     = rsp_x_ff;
   assign rsp_bus.y_position     = rsp_y_ff;
   assign rsp_bus.packet_status  = rsp_status_ff;
   assign rsp_bus.left_pressed   = rsp_status_ff[STAT_LEFT];
   assign rsp_bus.right_pressed  = rsp_status_ff[STAT_RIGHT];
   assign rsp_bus.middle_pressed = rsp_status_ff[STAT_MIDDLE];
   assign rsp_bus.x_overflowed   = rsp_status_ff[STAT_X_OVF];
   assign rsp_bus.y_overflowed   = rsp_status_ff[STAT_Y_OVF];

   a_dy_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept && idx_ff == IDX_DY |=> rsp_valid_ff)
      else $error("third packet beat did not load a result");

   a_no_move_midpacket: assert property (@(posedge clock) disable iff (reset)
      accept && idx_ff != IDX_DY |=> $stable(x_track_ff) && $stable(y_track_ff))
      else $error("pointer moved before the packet completed");

   a_x_in_screen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> CMP_W'(rsp_x_ff) < limit_of(cfg.screen_width))
      else $error("x result beyond screen width");

   a_y_in_screen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> CMP_W'(rsp_y_ff) < limit_of(cfg.screen_height))
      else $error("y result beyond screen height");

   a_idx_legal: assert property (@(posedge clock) disable iff (reset)
      idx_ff == IDX_STATUS || idx_ff == IDX_DX || idx_ff == IDX_DY)
      else $error("byte index left its legal codes");

endmodule

### hw/rtl/ps2_mouse_packet_tracker_top.sv
// Channel    Dir  Payload                                              Port
// req        in   data_byte[7:0]                                       req_bus (valid/ready)
// rsp        out  x/y_position, button and overflow flags, status[7:0] rsp_bus (valid/ready)
// csr        in   screen_width @0x0, screen_height @0x4 (13 bits)      csr_* (APB)
//
// One byte a cycle unless a Y-delta byte waits: each accepted byte updates packet
// state in the same cycle; the third byte loads the result register, seen next cycle.
// Status and X-delta bytes are taken even while a result waits; a Y-delta byte
// waits only when the result register is full and not drained in that cycle.
// Synchronous reset: limits 1024 x 768, pointer at (5, 2), next byte is status.
// Depends on ps2mt_pkg, ps2mt_if, ps2mt_csr and ps2mt_core.
module ps2_mouse_packet_tracker_top import ps2mt_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   ps2mt_req_if.sink                req_bus,
   ps2mt_rsp_if.source              rsp_bus,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   cfg_type cfg;

   ps2mt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ps2mt_core #(
      .COORD_BITS (COORD_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

endmodule

### test/tb.sv
// Self-checking bench for ps2_mouse_packet_tracker_top: drives byte beats with bursts,
// random back-pressure and APB writes of the screen limits, and checks every report.
// Depends on ps2mt_pkg, ps2mt_if and the RTL of the block.
module tb import ps2mt_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COORD_BITS  = COORD_BITS_DEF;
   localparam int COORD_SPAN  = 1 << COORD_BITS;
   localparam int PHASE_COUNT = 10;
   localparam int PHASE_BYTES = 115;
   localparam int DRAIN_WAIT  = 4;

   typedef enum bit [1:0] {
      SLOT_STATUS = 2'd0,
      SLOT_DX     = 2'd1,
      SLOT_DY     = 2'd2
   } byte_slot_type;
   typedef enum {DRIFT_ANY, DRIFT_UP, DRIFT_DOWN} drift_type;
   typedef enum {DRAIN_FREE, DRAIN_COIN, DRAIN_SPARSE, DRAIN_TOGGLE} drain_mode_type;

   typedef struct packed {
      bit [COORD_BITS-1:0] x_position;
      bit [COORD_BITS-1:0] y_position;
      bit                  left_pressed;
      bit                  right_pressed;
      bit                  middle_pressed;
      bit                  x_overflowed;
      bit                  y_overflowed;
      bit [7:0]            packet_status;
   } mouse_report_type;

   // Status, extremes of both deltas, every flag bit
   localparam bit [7:0] OPENING_PACKETS [24] = '{
      8'h00, 8'h00, 8'h00,
      8'h01, 8'h7F, 8'h80,
      8'h02, 8'h80, 8'h7F,
      8'h04, 8'hFF, 8'h01,
      8'h40, 8'h01, 8'hFF,
      8'h80, 8'h00, 8'h00,
      8'hFF, 8'h7F, 8'h7F,
      8'hB8, 8'h80, 8'h80
   };

   class pointer_report_checker;
      bit [DIM_BITS-1:0]   screen_w;
      bit [DIM_BITS-1:0]   screen_h;
      byte_slot_type       byte_slot;
      bit [7:0]            status_hold;
      bit [7:0]            dx_hold;
      bit [COORD_BITS-1:0] x_pos;
      bit [COORD_BITS-1:0] y_pos;
      mouse_report_type    pending_reports[$];
      int unsigned         reports_checked;
      int unsigned         failures;

      function new();
         screen_w  = SCREEN_WIDTH_RST;
         screen_h  = SCREEN_HEIGHT_RST;
         byte_slot = SLOT_STATUS;
         status_hold = '0;
         dx_hold   = '0;
         x_pos     = COORD_BITS'(X_TRACK_RST);
         y_pos     = COORD_BITS'(Y_TRACK_RST);
         reports_checked = 0;
         failures  = 0;
      endfunction

      function void set_limit(logic reg_index, bit [CSR_DATA_BITS-1:0] word);
         if (reg_index == REG_SCREEN_WIDTH)
            screen_w = word[DIM_BITS-1:0];
         else
            screen_h = word[DIM_BITS-1:0];
      endfunction

      // Zero acts as one; anything past the coordinate span is capped
      function bit [COORD_BITS-1:0] clamp_to_screen(int pos, bit [DIM_BITS-1:0] limit_reg);
         int lim;
         lim = limit_reg;
         if (lim < 1) lim = 1;
         if (lim > COORD_SPAN) lim = COORD_SPAN;
         if (pos < 0) pos = 0;
         if (pos >= lim) pos = lim - 1;
         return pos[COORD_BITS-1:0];
      endfunction

      function void take_byte(bit [7:0] data);
         mouse_report_type next_report;
         int               nx;
         int               ny;
         case (byte_slot)
            SLOT_DX: begin
               dx_hold   = data;
               byte_slot = SLOT_DY;
            end
            SLOT_DY: begin
               nx = int'(x_pos) + int'($signed(dx_hold));
               ny = int'(y_pos) - int'($signed(data));
               x_pos = clamp_to_screen(nx, screen_w);
               y_pos = clamp_to_screen(ny, screen_h);
               next_report.x_position     = x_pos;
               next_report.y_position     = y_pos;
               next_report.left_pressed   = status_hold[STAT_LEFT];
               next_report.right_pressed  = status_hold[STAT_RIGHT];
               next_report.middle_pressed = status_hold[STAT_MIDDLE];
               next_report.x_overflowed   = status_hold[STAT_X_OVF];
               next_report.y_overflowed   = status_hold[STAT_Y_OVF];
               next_report.packet_status  = status_hold;
               pending_reports.push_back(next_report);
               byte_slot = SLOT_STATUS;
            end
            default: begin
               status_hold = data;
               byte_slot   = SLOT_DX;
            end
         endcase
      endfunction

      function void match_field(string field, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            failures++;
         end
      endfunction

      function void check_report(mouse_report_type got);
         mouse_report_type want;
         if (pending_reports.size() == 0) begin
            $error("report with no packet pending: x %0d y %0d status 0x%02h",
                   got.x_position, got.y_position, got.packet_status);
            failures++;
            return;
         end
         want = pending_reports.pop_front();
         reports_checked++;
         match_field("x_position", want.x_position, got.x_position);
         match_field("y_position", want.y_position, got.y_position);
         match_field("left_pressed", want.left_pressed, got.left_pressed);
         match_field("right_pressed", want.right_pressed, got.right_pressed);
         match_field("middle_pressed", want.middle_pressed, got.middle_pressed);
         match_field("x_overflowed", want.x_overflowed, got.x_overflowed);
         match_field("y_overflowed", want.y_overflowed, got.y_overflowed);
         match_field("packet_status", want.packet_status, got.packet_status);
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;
   int                       burst_left = 0;

   pointer_report_checker board = new();

   ps2mt_req_if req_bus ();
   ps2mt_rsp_if #(.COORD_BITS(COORD_BITS)) rsp_bus ();

   ps2_mouse_packet_tracker_top #(.COORD_BITS(COORD_BITS)) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task write_limit(input logic reg_index, input bit [DIM_BITS-1:0] limit);
      bit [CSR_DATA_BITS-1:0] word;
      word = $urandom();
      word[DIM_BITS-1:0] = limit;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_index, 2'b00};
      csr_pwdata  <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      board.set_limit(reg_index, word);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task offer_byte(input bit [7:0] data);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= data;
      do @(posedge clock); while (!req_bus.ready);
      board.take_byte(data);
   endtask

   // Hold the sender until every report is back, then let the pipe settle
   task drain_reports();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      while (board.pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   function bit [7:0] pick_delta(drift_type drift);
      case (drift)
         DRIFT_UP:   return 8'($urandom_range(0, 127));
         DRIFT_DOWN: return 8'($urandom_range(128, 255));
         default: begin
            if ($urandom_range(0, 4) == 0)
               case ($urandom_range(0, 3))
                  0:       return 8'h00;
                  1:       return 8'h7F;
                  2:       return 8'h80;
                  default: return 8'hFF;
               endcase
            return 8'($urandom_range(0, 255));
         end
      endcase
   endfunction

   initial begin
      bit [DIM_BITS-1:0] widths  [PHASE_COUNT];
      bit [DIM_BITS-1:0] heights [PHASE_COUNT];
      drift_type         drift;
      bit [7:0]          data;

      widths  = '{13'd1024, 13'd1, 13'd0, 13'd4096, 13'd8191, 13'd4097, 13'd2, 13'd13,
                  13'd640, 13'd0};
      heights = '{13'd768, 13'd1, 13'd0, 13'd4096, 13'd8191, 13'd2, 13'd4095, 13'd7,
                  13'd480, 13'd0};
      widths[PHASE_COUNT-1]  = 13'($urandom_range(0, 8191));
      heights[PHASE_COUNT-1] = 13'($urandom_range(0, 8191));
      drift = DRIFT_ANY;

      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.data_byte <= 8'h00;
      csr_psel          <= 1'b0;
      csr_penable       <= 1'b0;
      csr_pwrite        <= 1'b0;
      csr_paddr         <= '0;
      csr_pwdata        <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Limits below the reset position: the first packet must pull it inside
      write_limit(REG_SCREEN_WIDTH, 13'd4);
      write_limit(REG_SCREEN_HEIGHT, 13'd2);
      foreach (OPENING_PACKETS[i])
         offer_byte(OPENING_PACKETS[i]);
      drain_reports();

      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_limit(REG_SCREEN_WIDTH, widths[p]);
         write_limit(REG_SCREEN_HEIGHT, heights[p]);
         for (int n = 0; n < PHASE_BYTES; n++) begin
            if (n % 40 == 0)
               drift = drift_type'($urandom_range(0, 2));
            if (board.byte_slot == SLOT_STATUS)
               data = 8'($urandom_range(0, 255));
            else
               data = pick_delta(drift);
            offer_byte(data);
         end
         drain_reports();
      end

      repeat (10) @(posedge clock);
      if (board.failures == 0)
         $display("ps2_mouse_packet_tracker_top verification clean");
      else
         $display("ps2_mouse_packet_tracker_top verification failed");
      $finish;
   end

   // Receiver back-pressure, with one long hold-off to fill the block
   initial begin
      drain_mode_type drain_mode;
      bit             long_hold_done;
      long_hold_done = 1'b0;
      rsp_bus.ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (!long_hold_done && board.reports_checked >= 60) begin
            long_hold_done = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (400) @(posedge clock);
         end
         drain_mode = drain_mode_type'($urandom_range(0, 3));
         repeat ($urandom_range(8, 60)) begin
            case (drain_mode)
               DRAIN_FREE:   rsp_bus.ready <= 1'b1;
               DRAIN_COIN:   rsp_bus.ready <= 1'($urandom_range(0, 1));
               DRAIN_SPARSE: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               default:      rsp_bus.ready <= !rsp_bus.ready;
            endcase
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin : watch_reports
      mouse_report_type seen;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen.x_position     = rsp_bus.x_position;
         seen.y_position     = rsp_bus.y_position;
         seen.left_pressed   = rsp_bus.left_pressed;
         seen.right_pressed  = rsp_bus.right_pressed;
         seen.middle_pressed = rsp_bus.middle_pressed;
         seen.x_overflowed   = rsp_bus.x_overflowed;
         seen.y_overflowed   = rsp_bus.y_overflowed;
         seen.packet_status  = rsp_bus.packet_status;
         board.check_report(seen);
      end
   end

   initial begin
      #3_000_000;
      $display("ps2_mouse_packet_tracker_top verification failed");
      $finish;
   end

endmodule

### sim.f
hw/rtl/ps2mt_pkg.sv
hw/rtl/ps2mt_if.sv
hw/rtl/ps2mt_csr.sv
hw/rtl/ps2mt_core.sv
hw/rtl/ps2_mouse_packet_tracker_top.sv
test/tb.sv
